@@ rtl/lspf_pkg.sv @@
`timescale 1ns / 1ps
package lspf_pkg;

  localparam int MaxDegree = 3;
  localparam int MaxPoints = 256;
  localparam int CntW      = $clog2(MaxPoints + 1);

  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

  // commands from the controller to the datapath
  typedef enum logic [3:0] {
    OP_NONE,
    OP_POW,     // one step of the power chain for the held sample
    OP_LOAD,    // copy sums into the work matrix
    OP_FACT,    // start factor division m[i][k] / m[k][k]
    OP_ELIM,    // m[i][j] -= f * m[k][j], j = col
    OP_BACC,    // acc += m[i][k] * s[k]
    OP_BDIV,    // start s[i] = (m[i][4] - acc) / m[i][i]
    OP_CLEAR,   // clear sums after solve
    OP_ACLR     // clear back-substitution accumulator
  } op_t;

  typedef struct packed {
    op_t      op;
    logic [1:0] row;
    logic [1:0] col;
    logic [2:0] step;
    logic [1:0] piv;
  } cmd_t;

  typedef struct packed {
    logic busy;       // multiplier or divider at work
    logic zero_piv;   // divisor of current division is zero
  } stat_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // magnitude plus overflow and sign back to saturated two's complement
  function automatic logic signed [63:0] finish(input logic [63:0] m, input logic ovf,
                                                input logic neg);
    if (neg) begin
      if (ovf || m[63]) return SMIN;
      return 64'd0 - m;
    end
    if (ovf || m[63]) return SMAX;
    return m;
  endfunction

endpackage

@@ rtl/lspf_if.sv @@
`timescale 1ns / 1ps
interface lspf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_sample;
  logic signed [31:0] y_sample;
  logic               last_point;
  modport source (output valid, x_sample, y_sample, last_point, input ready);
  modport sink   (input valid, x_sample, y_sample, last_point, output ready);
endinterface

interface lspf_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         coef_index;
  logic signed [47:0] coef_value;
  logic               singular;
  logic               last_coef;
  modport source (output valid, coef_index, coef_value, singular, last_coef, input ready);
  modport sink   (input valid, coef_index, coef_value, singular, last_coef, output ready);
endinterface

@@ rtl/lspf_mul.sv @@
`timescale 1ns / 1ps
// Signed multiply with rounding shift and saturation: round(a*b / 2^sh).
// 64x64 magnitude product built from four 32x32 partial products accumulated
// in turn, then rounded and saturated.
module lspf_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic               sh32,    // 1: shift 32, 0: shift 16
  output logic               busy,
  output logic               done,
  output logic signed [63:0] result
);
  logic [63:0]  ma, mb;
  logic         neg, s32;
  logic [2:0]   phase;
  logic [127:0] acc;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] rnd;
  logic [63:0]  m;
  logic         ovf;

  // pick the partial product of this phase
  always_comb begin
    unique case (phase[1:0])
      2'd0: begin pa = ma[31:0];  pb = mb[31:0];  end
      2'd1: begin pa = ma[31:0];  pb = mb[63:32]; end
      2'd2: begin pa = ma[63:32]; pb = mb[31:0];  end
      default: begin pa = ma[63:32]; pb = mb[63:32]; end
    endcase
    pp = 64'(pa) * 64'(pb);
  end

  always_comb begin
    rnd = acc + (s32 ? (128'd1 << 31) : (128'd1 << 15));
    if (s32) begin
      m   = rnd[95:32];
      ovf = |rnd[127:96];
    end else begin
      m   = rnd[79:16];
      ovf = |rnd[127:80];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= '0;
      ma    <= lspf_pkg::mag(a);
      mb    <= lspf_pkg::mag(b);
      neg   <= a[63] ^ b[63];
      s32   <= sh32;
      acc   <= '0;
    end else if (busy) begin
      if (phase == 3'd4) begin
        result <= lspf_pkg::finish(m, ovf, neg);
        busy   <= 1'b0;
        done   <= 1'b1;
      end else begin
        unique case (phase[1:0])
          2'd0: acc <= acc + 128'(pp);
          2'd1, 2'd2: acc <= acc + (128'(pp) << 32);
          default: acc <= acc + (128'(pp) << 64);
        endcase
        phase <= phase + 3'd1;
      end
    end
  end
endmodule

@@ rtl/lspf_div.sv @@
`timescale 1ns / 1ps
// Restoring divider: round(num * 2^32 / den), saturated, zero divisor
// gives zero. One quotient bit per cycle over 96 dividend bits.
module lspf_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               busy,
  output logic               done,
  output logic signed [63:0] result
);
  logic [95:0]  dvd;
  logic [63:0]  ud;
  logic [64:0]  r;
  logic [95:0]  q;
  logic [6:0]   cnt;
  logic         neg;
  logic [64:0]  rs;
  logic [64:0]  diff;
  logic [63:0]  ql;
  logic         qov;

  always_comb begin
    rs   = {r[63:0], dvd[95]};
    diff = rs - {1'b0, ud};
    // round: remainder at least half the divisor
    ql   = q[63:0] + 64'(r >= ({1'b0, ud} - r));
    qov  = (|q[95:64]) || (q[63:0] == 64'hFFFF_FFFF_FFFF_FFFF && r >= ({1'b0, ud} - r));
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      if (den == 64'sd0) begin
        result <= '0;
        done   <= 1'b1;
      end else begin
        busy <= 1'b1;
        dvd  <= {lspf_pkg::mag(num), 32'd0};
        ud   <= lspf_pkg::mag(den);
        neg  <= num[63] ^ den[63];
        r    <= '0;
        q    <= '0;
        cnt  <= 7'd96;
      end
    end else if (busy) begin
      if (cnt == 7'd0) begin
        result <= lspf_pkg::finish(ql, qov, neg);
        busy   <= 1'b0;
        done   <= 1'b1;
      end else begin
        dvd <= dvd << 1;
        if (!diff[64]) begin
          r <= diff;
          q <= {q[94:0], 1'b1};
        end else begin
          r <= rs;
          q <= {q[94:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
      end
    end
  end
endmodule

@@ rtl/lspf_datapath.sv @@
`timescale 1ns / 1ps
// Sums, work matrix, solutions and the shared multiplier and divider.
module lspf_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,        // capture a sample
  input  logic signed [31:0]  x_in,
  input  logic signed [31:0]  y_in,
  input  lspf_pkg::cmd_t      cmd,
  input  logic [1:0]          out_idx,
  output lspf_pkg::stat_t     stat,
  output logic signed [47:0]  coef
);
  logic signed [63:0] psum [7];
  logic signed [63:0] msum [4];
  logic signed [63:0] wm   [4][5];
  logic signed [63:0] sol  [4];
  logic signed [63:0] xr, yr, pw, fac, acc;

  logic               mstart, msh32, mbusy, mdone;
  logic signed [63:0] ma, mb, mres;
  logic               dstart, dbusy, ddone;
  logic signed [63:0] dnum, dden, dres;

  logic               pend_moment;  // second product of a power step
  logic               pend_start;   // launch p * x this cycle
  lspf_pkg::cmd_t     hold;

  lspf_mul u_mul (.clk, .rst, .start(mstart), .a(ma), .b(mb), .sh32(msh32),
                  .busy(mbusy), .done(mdone), .result(mres));
  lspf_div u_div (.clk, .rst, .start(dstart), .num(dnum), .den(dden),
                  .busy(dbusy), .done(ddone), .result(dres));

  // operand selection for the current command
  always_comb begin
    mstart = 1'b0;
    msh32  = 1'b1;
    ma     = fac;
    mb     = wm[cmd.piv][cmd.col + 3'd0];
    dstart = 1'b0;
    dnum   = wm[cmd.row][cmd.piv];
    dden   = wm[cmd.piv][cmd.piv];
    unique case (cmd.op)
      lspf_pkg::OP_POW: begin
        mstart = 1'b1;
        msh32  = 1'b0;
        ma     = yr;
        mb     = pw;
      end
      lspf_pkg::OP_ELIM: begin
        mstart = 1'b1;
        mb     = (cmd.step == 3'd4) ? wm[cmd.piv][4] : wm[cmd.piv][cmd.col];
      end
      lspf_pkg::OP_BACC: begin
        mstart = 1'b1;
        ma     = wm[cmd.row][cmd.piv];
        mb     = sol[cmd.piv];
      end
      lspf_pkg::OP_FACT: dstart = 1'b1;
      lspf_pkg::OP_BDIV: begin
        dstart = 1'b1;
        dnum   = lspf_pkg::sat_sub(wm[cmd.row][4], acc);
        dden   = wm[cmd.row][cmd.row];
      end
      default: ;
    endcase
    // second product of a power step: p * x
    if (pend_start) begin
      mstart = 1'b1;
      msh32  = 1'b0;
      ma     = pw;
      mb     = xr;
    end
  end

  always_comb begin
    logic signed [63:0] v;
    logic [63:0]        mv;
    v  = sol[out_idx];
    mv = lspf_pkg::mag(v);
    v  = lspf_pkg::finish({8'd0, mv[63:8]} + 64'(mv[7]), 1'b0, v[63]);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) coef = 48'sh7FFF_FFFF_FFFF;
    else if (v < -64'sh0000_8000_0000_0000) coef = 48'sh8000_0000_0000;
    else coef = v[47:0];
  end

  assign stat.busy     = mbusy | dbusy | mstart | dstart | mdone | ddone | pend_moment;
  assign stat.zero_piv = (dden == 64'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_moment <= 1'b0;
      for (int i = 0; i < 7; i++) psum[i] <= '0;
      for (int i = 0; i < 4; i++) msum[i] <= '0;
    end else begin
      if (load) begin
        xr <= 64'(x_in);
        yr <= 64'(y_in);
        pw <= lspf_pkg::ONE_Q32;
      end
      if ((mstart || dstart) && !pend_start) hold <= cmd;
      // power step: add p, start moment y*p then p*x
      if (cmd.op == lspf_pkg::OP_POW) begin
        psum[cmd.step] <= lspf_pkg::sat_add(psum[cmd.step], pw);
      end
      if (mdone) begin
        unique case (hold.op)
          lspf_pkg::OP_POW: begin
            if (!pend_moment) begin
              if (hold.step < 3'd4)
                msum[hold.step[1:0]] <= lspf_pkg::sat_add(msum[hold.step[1:0]], mres);
              pend_moment <= 1'b1;
            end else begin
              pw          <= mres;
              pend_moment <= 1'b0;
            end
          end
          lspf_pkg::OP_ELIM: begin
            if (hold.step == 3'd4)
              wm[hold.row][4] <= lspf_pkg::sat_sub(wm[hold.row][4], mres);
            else
              wm[hold.row][hold.col] <= lspf_pkg::sat_sub(wm[hold.row][hold.col], mres);
          end
          lspf_pkg::OP_BACC: acc <= lspf_pkg::sat_add(acc, mres);
          default: ;
        endcase
      end
      if (ddone) begin
        if (hold.op == lspf_pkg::OP_FACT) fac <= dres;
        else sol[hold.row] <= dres;
      end
      if (cmd.op == lspf_pkg::OP_ACLR) acc <= '0;
      if (cmd.op == lspf_pkg::OP_LOAD) begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) wm[i][j] <= psum[i + j];
          wm[i][4] <= msum[i];
        end
      end
      if (cmd.op == lspf_pkg::OP_CLEAR) begin
        for (int i = 0; i < 7; i++) psum[i] <= '0;
        for (int i = 0; i < 4; i++) msum[i] <= '0;
      end
    end
  end

  // reuse the multiplier for p*x in the cycle after the moment product completes
  always_ff @(posedge clk) begin
    if (rst) pend_start <= 1'b0;
    else pend_start <= mdone && hold.op == lspf_pkg::OP_POW && !pend_moment;
  end
endmodule

@@ rtl/least_squares_poly_fit.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_ch     in   x_sample, y_sample, last_point
// out_ch    out  coef_index, coef_value, singular, last_coef
// cfg       in   cfg_we, cfg_data (degree)
//
// Each sample, up to 256 per fit, holds the input through seven power steps,
// each step two products in the shared 64-bit multiplier. The solve is serial
// through the same multiplier and a 96-step restoring divider.
// Reset is synchronous and clears the sums and the controller.
// Results wait in an output register; a stall holds the controller.
module least_squares_poly_fit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  lspf_in_if.sink    in_ch,
  lspf_out_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_POW, S_POWW, S_LOAD, S_FACT, S_FACTW, S_ELIM, S_ELIMW,
    S_ACLR, S_BACC, S_BACCW, S_BDIV, S_BDIVW, S_EMIT, S_CLEAR
  } state_t;

  state_t             state;
  logic [1:0]         degree;
  logic [1:0]         nm1;
  logic [lspf_pkg::CntW-1:0] count;
  logic               last_r, take, singular_r;
  logic [2:0]         step;
  logic [1:0]         k, i, j;
  lspf_pkg::cmd_t     cmd;
  lspf_pkg::stat_t    stat;
  logic signed [47:0] coef;
  logic [1:0]         oidx;
  logic               ovalid, mphase;

  assign take        = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) degree <= 2'd1;
    else if (cfg_we) degree <= cfg_data;
  end

  always_comb begin
    unique case (degree)
      2'd0, 2'd1: nm1 = 2'd1;
      2'd2:       nm1 = 2'd2;
      default:    nm1 = 2'd3;
    endcase
  end

  lspf_datapath u_dp (.clk, .rst, .load(take), .x_in(in_ch.x_sample),
                      .y_in(in_ch.y_sample), .cmd, .out_idx(oidx), .stat, .coef);

  // command to the datapath
  always_comb begin
    cmd      = '0;
    cmd.op   = lspf_pkg::OP_NONE;
    cmd.row  = i;
    cmd.col  = j;
    cmd.step = step;
    cmd.piv  = k;
    unique case (state)
      S_POW:   cmd.op = (mphase ? lspf_pkg::OP_NONE : lspf_pkg::OP_POW);
      S_LOAD:  cmd.op = lspf_pkg::OP_LOAD;
      S_FACT:  cmd.op = lspf_pkg::OP_FACT;
      S_ELIM:  cmd.op = lspf_pkg::OP_ELIM;
      S_ACLR:  cmd.op = lspf_pkg::OP_ACLR;
      S_BACC:  cmd.op = lspf_pkg::OP_BACC;
      S_BDIV:  cmd.op = lspf_pkg::OP_BDIV;
      S_CLEAR: cmd.op = lspf_pkg::OP_CLEAR;
      default: ;
    endcase
  end

  assign out_ch.valid      = ovalid;
  assign out_ch.coef_index = oidx;
  assign out_ch.coef_value = singular_r ? 48'sd0 : coef;
  assign out_ch.singular   = singular_r;
  assign out_ch.last_coef  = (oidx == nm1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ovalid <= 1'b0;
      mphase <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (take) begin
          last_r <= in_ch.last_point;
          step   <= '0;
          if (count < lspf_pkg::CntW'(lspf_pkg::MaxPoints)) begin
            count <= count + 1'b1;
            state <= S_POW;
          end else if (in_ch.last_point) begin
            state <= S_LOAD;
          end
        end
        S_POW: state <= S_POWW;
        S_POWW: if (!stat.busy) begin
          if (step == 3'd6) state <= last_r ? S_LOAD : S_IDLE;
          else begin step <= step + 3'd1; state <= S_POW; end
        end
        S_LOAD: begin
          singular_r <= 1'b0;
          k <= '0; i <= 2'd1;
          state <= S_FACT;
        end
        S_FACT: state <= S_FACTW;
        S_FACTW: if (!stat.busy) begin j <= k; step <= '0; state <= S_ELIM; end
        S_ELIM: state <= S_ELIMW;
        S_ELIMW: if (!stat.busy) begin
          if (step == 3'd4) begin
            if (i != nm1) begin i <= i + 2'd1; state <= S_FACT; end
            else if (k + 2'd1 != nm1) begin
              k <= k + 2'd1; i <= k + 2'd2; state <= S_FACT;
            end else begin i <= nm1; state <= S_ACLR; end
          end else if (j == nm1) step <= 3'd4;
          else begin j <= j + 2'd1; state <= S_ELIM; end
          if (step != 3'd4 && j == nm1) state <= S_ELIM;
        end
        S_ACLR: begin k <= nm1; state <= (i == nm1) ? S_BDIV : S_BACC; end
        S_BACC: state <= S_BACCW;
        S_BACCW: if (!stat.busy) begin
          if (k == i + 2'd1) state <= S_BDIV;
          else begin k <= k - 2'd1; state <= S_BACC; end
        end
        S_BDIV: begin
          if (stat.zero_piv) singular_r <= 1'b1;
          state <= S_BDIVW;
        end
        S_BDIVW: if (!stat.busy) begin
          if (i == 2'd0) begin oidx <= '0; ovalid <= 1'b1; state <= S_EMIT; end
          else begin i <= i - 2'd1; state <= S_ACLR; end
        end
        S_EMIT: if (out_ch.ready) begin
          if (oidx == nm1) begin ovalid <= 1'b0; state <= S_CLEAR; end
          else oidx <= oidx + 2'd1;
        end
        default: begin count <= '0; state <= S_IDLE; end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) ovalid |-> state == S_EMIT)
    else $error("result shown outside emit");
  assert property (@(posedge clk) disable iff (rst) take |-> !ovalid)
    else $error("sample taken while results pending");
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(oidx))
    else $error("stalled result moved");
endmodule

@@ tb/sv/lspf_fit_checker.sv @@
`timescale 1ns / 1ps
module lspf_fit_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  lspf_in_if         samples,
  lspf_out_if        coefs,
  output int         fails,
  output int         owed,
  output int         coefs_seen,
  output int         solves
);
  typedef struct packed {
    logic [1:0]  idx;
    logic [47:0] value;
    logic        sing;
    logic        lastc;
  } coef_t;

  localparam logic signed [63:0] TOP64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] BOT64 = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] TOP48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] BOT48 = -64'sh0000_8000_0000_0000;

  logic [1:0]         fit_degree;
  logic signed [63:0] pow_acc [7];
  logic signed [63:0] mom_acc [4];
  logic signed [63:0] mat [4][5];
  logic signed [63:0] sol [4];
  int                 taken;
  coef_t              coef_q [$];

  function automatic logic signed [63:0] add_clip(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? BOT64 : TOP64;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_clip(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? BOT64 : TOP64;
    return s[63:0];
  endfunction

  function automatic logic [63:0] absval(logic signed [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // apply sign to a magnitude, clipping to the 64-bit range
  function automatic logic signed [63:0] signed_clip(logic [127:0] m, logic neg);
    if (neg) begin
      if (m > 128'h8000_0000_0000_0000) return BOT64;
      return 64'd0 - m[63:0];
    end
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) return TOP64;
    return m[63:0];
  endfunction

  function automatic logic signed [63:0] mul_round(logic signed [63:0] a, logic signed [63:0] b,
                                                  int sh);
    logic [127:0] p;
    p = {64'd0, absval(a)} * {64'd0, absval(b)};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    return signed_clip(p, a[63] != b[63]);
  endfunction

  function automatic logic signed [63:0] div_round(logic signed [63:0] num,
                                                  logic signed [63:0] den, int sh);
    logic [127:0] n, d, q, r;
    if (den == 0) return 0;
    n = {64'd0, absval(num)} << sh;
    d = {64'd0, absval(den)};
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return signed_clip(q, num[63] != den[63]);
  endfunction

  // accumulate one sample and, on the last one, solve and queue the coefficients
  function automatic void take_sample(logic signed [31:0] x, logic signed [31:0] y, logic lst);
    logic signed [63:0] p, piv, f, acc, v;
    int                 n, d;
    logic               sing;
    coef_t              c;
    if (taken < lspf_pkg::MaxPoints) begin
      p = lspf_pkg::ONE_Q32;
      for (int k = 0; k < 7; k++) begin
        pow_acc[k] = add_clip(pow_acc[k], p);
        if (k < 4) mom_acc[k] = add_clip(mom_acc[k], mul_round(64'(y), p, 16));
        p = mul_round(p, 64'(x), 16);
      end
      taken++;
    end
    if (!lst) return;
    d = (fit_degree == 0) ? 1 : int'(fit_degree);
    n = d + 1;
    sing = 1'b0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) mat[i][j] = pow_acc[i + j];
      mat[i][4] = mom_acc[i];
    end
    // forward elimination, no pivoting
    for (int k = 0; k < n - 1; k++) begin
      piv = mat[k][k];
      for (int i = k + 1; i < n; i++) begin
        f = div_round(mat[i][k], piv, 32);
        for (int j = k; j < n; j++) mat[i][j] = sub_clip(mat[i][j], mul_round(f, mat[k][j], 32));
        mat[i][4] = sub_clip(mat[i][4], mul_round(f, mat[k][4], 32));
      end
    end
    // back substitution
    for (int i = n - 1; i >= 0; i--) begin
      acc = 0;
      for (int k = n - 1; k > i; k--) acc = add_clip(acc, mul_round(mat[i][k], sol[k], 32));
      if (mat[i][i] == 0) sing = 1'b1;
      sol[i] = div_round(sub_clip(mat[i][4], acc), mat[i][i], 32);
    end
    for (int i = 0; i < n; i++) begin
      v = mul_round(sol[i], 64'sd1, 8);
      if (v > TOP48) v = TOP48;
      if (v < BOT48) v = BOT48;
      if (sing) v = 0;
      c.idx   = 2'(i);
      c.value = v[47:0];
      c.sing  = sing;
      c.lastc = (i == n - 1);
      coef_q.push_back(c);
    end
    for (int k = 0; k < 7; k++) pow_acc[k] = 0;
    for (int k = 0; k < 4; k++) mom_acc[k] = 0;
    taken = 0;
    solves++;
  endfunction

  initial begin
    fails = 0;
    owed = 0;
    coefs_seen = 0;
    solves = 0;
  end

  always @(posedge clk) begin
    coef_t e;
    if (rst) begin
      fit_degree = 2'd1;
      for (int k = 0; k < 7; k++) pow_acc[k] = 0;
      for (int k = 0; k < 4; k++) mom_acc[k] = 0;
      taken = 0;
      coef_q.delete();
    end else begin
      if (cfg_we) fit_degree = cfg_data;
      if (samples.valid && samples.ready)
        take_sample(samples.x_sample, samples.y_sample, samples.last_point);
      // compare each coefficient with the oldest one owed
      if (coefs.valid && coefs.ready) begin
        coefs_seen++;
        if (coef_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected coefficient idx=%0d value=%h", $time,
                   coefs.coef_index, coefs.coef_value);
        end else begin
          e = coef_q.pop_front();
          if (coefs.coef_index !== e.idx) begin
            fails++;
            $display("%0t: coef_index expected %0d actual %0d", $time, e.idx, coefs.coef_index);
          end
          if (coefs.coef_value !== e.value) begin
            fails++;
            $display("%0t: coef_value expected %h actual %h", $time, e.value, coefs.coef_value);
          end
          if (coefs.singular !== e.sing) begin
            fails++;
            $display("%0t: singular expected %b actual %b", $time, e.sing, coefs.singular);
          end
          if (coefs.last_coef !== e.lastc) begin
            fails++;
            $display("%0t: last_coef expected %b actual %b", $time, e.lastc, coefs.last_coef);
          end
        end
      end
    end
    owed = coef_q.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  localparam int CycleLimit = 1000000;
  localparam int ChokeLen   = 3000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_data = 2'd0;
  int         cyc = 0;
  int         sent = 0;
  int         fails, owed, coefs_seen, solves;
  logic       choke_go = 1'b0;
  logic       choke_done = 1'b0;
  int         choke_left = 0;
  logic       tx_calm = 1'b0;

  lspf_in_if  samples ();
  lspf_out_if coefs ();

  least_squares_poly_fit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (samples),
    .out_ch   (coefs)
  );

  lspf_fit_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .samples    (samples),
    .coefs      (coefs),
    .fails      (fails),
    .owed       (owed),
    .coefs_seen (coefs_seen),
    .solves     (solves)
  );

  always #6 clk = ~clk;

  // count cycles and stop a hung run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, one calm window, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      coefs.ready <= 1'b0;
    end else if (choke_left > 0) begin
      coefs.ready <= 1'b0;
      choke_left <= choke_left - 1;
    end else if (choke_go && !choke_done) begin
      coefs.ready <= 1'b0;
      choke_left <= ChokeLen;
      choke_done <= 1'b1;
    end else if (cyc >= 6000 && cyc < 14000) begin
      coefs.ready <= 1'b1;
    end else begin
      coefs.ready <= ($urandom_range(99) >= 17);
    end
  end

  function automatic logic [31:0] coord(logic wide);
    if (wide) return $urandom;
    return $urandom_range(32'h0010_0000) - 32'h0008_0000;
  endfunction

  // offer one request and hold it until taken
  task automatic put_point(logic [31:0] x, logic [31:0] y, logic lst);
    if (!tx_calm && $urandom_range(99) < 17) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    samples.valid      <= 1'b1;
    samples.x_sample   <= x;
    samples.y_sample   <= y;
    samples.last_point <= lst;
    do @(posedge clk); while (!samples.ready);
    sent++;
  endtask

  // drain every owed coefficient, then let the block settle
  task automatic drain();
    samples.valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_degree(logic [1:0] d);
    cfg_we   <= 1'b1;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int len;
    logic wide;
    logic held;
    held = 1'b0;
    samples.valid      = 1'b0;
    samples.x_sample   = '0;
    samples.y_sample   = '0;
    samples.last_point = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // linear fit through three points at the reset degree
    put_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    put_point(32'h0001_0000, 32'h0001_0000, 1'b0);
    put_point(32'h0002_0000, 32'h0003_0000, 1'b1);
    drain();
    // quadratic from one point: singular
    set_degree(2'd2);
    put_point(32'h0003_0000, 32'hFFFE_0000, 1'b1);
    drain();
    // cubic with extreme samples
    set_degree(2'd3);
    put_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    put_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    put_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    put_point(32'h0000_0000, 32'h0000_0000, 1'b1);
    drain();
    // well-posed cubic
    put_point(32'hFFFF_0000, 32'h0001_0000, 1'b0);
    put_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    put_point(32'h0001_0000, 32'h0001_0000, 1'b0);
    put_point(32'h0002_0000, 32'h0008_0000, 1'b1);
    drain();
    // degree zero acts as linear
    set_degree(2'd0);
    put_point(32'h0001_0000, 32'h0002_0000, 1'b0);
    put_point(32'h0003_8000, 32'h0004_4000, 1'b1);
    drain();

    // random sets, mostly well-formed fits of modest range; keep sending
    // through the long hold-off so the block stalls its input
    while (sent < 52) begin
      if (!held && $urandom_range(2) == 0) set_degree(2'($urandom_range(3)));
      len = $urandom_range(1, 10);
      wide = ($urandom_range(99) < 25);
      tx_calm = (sent >= 20 && sent < 40);
      if (sent >= 30) choke_go <= 1'b1;
      for (int i = 0; i < len; i++)
        put_point(coord(wide), coord(wide), i == len - 1);
      if (choke_left > 0) begin
        held = 1'b1;
      end else begin
        drain();
        held = 1'b0;
      end
    end
    if (held) drain();

    // more points than the block keeps
    set_degree(2'd1);
    for (int i = 0; i <= lspf_pkg::MaxPoints; i++)
      put_point(coord(1'b0), coord(1'b0), i == lspf_pkg::MaxPoints);
    drain();
    set_degree(2'd3);
    for (int i = 0; i < 6; i++) put_point(coord(1'b0), coord(1'b0), i == 5);
    drain();

    $display("%0d samples sent, %0d fits solved, %0d coefficients checked", sent, solves,
             coefs_seen);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
